// File: rtl/pkfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer package
// Shared character codes, the configuration bundle and the result queue entry.
// ----------------------------------------------------------------------------
package pkfr_pkg;

  localparam logic [7:0] CHAR_BANG = 8'h21;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_B    = 8'h42;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_Q    = 8'h51;

  // Only the head of a packet is ever decoded, so only these bytes are kept.
  localparam int DECODE_BYTES  = 14;
  localparam int PAYLOAD_BYTES = 12;

  typedef struct packed {
    logic [15:0] idle_limit;
    logic [4:0]  accel_len;
    logic [4:0]  gyro_len;
    logic [4:0]  magnet_len;
    logic [4:0]  quat_len;
    logic [4:0]  button_len;
    logic [4:0]  color_len;
    logic [4:0]  location_len;
  } cfg_t;

  typedef struct packed {
    logic                          kind;
    logic [PAYLOAD_BYTES-1:0][7:0] data;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/pkfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer front end
// Accepts bytes and idle ticks, tracks the packet position and idle count,
// and queues a head snapshot of each closed button or accelerometer packet.
// ----------------------------------------------------------------------------
module pkfr_front #(
  parameter int BUFFER_BYTES = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pkfr_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             action,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             q_full,
  output logic                  q_push,
  output pkfr_pkg::entry_t      q_entry
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = (PW > 5) ? PW : 5;
  localparam int DB = pkfr_pkg::DECODE_BYTES;
  localparam int PB = pkfr_pkg::PAYLOAD_BYTES;

  logic [DB-1:0][7:0] pkt;
  logic [PW-1:0]      pos;
  logic [15:0]        idle_count;

  logic               accept;
  logic               is_byte;
  logic [PW-1:0]      wpos;
  logic [PW-1:0]      newpos;
  logic [PW-1:0]      cpos;
  logic [DB-1:0][7:0] view;
  logic [DB-1:0][7:0] eff;
  logic [15:0]        idle_next;
  logic [4:0]         len;
  logic               len_known;
  logic               len_hit;
  logic               close;
  logic               emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_byte  = !action;

  always_comb begin
    wpos   = (rx_byte == pkfr_pkg::CHAR_BANG) ? '0 : pos;
    newpos = wpos + 1'b1;
    view   = pkt;
    if (is_byte) begin
      for (int i = 0; i < DB; i++) begin
        if (wpos == PW'(i)) begin
          view[i] = rx_byte;
        end
      end
    end
    idle_next = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;
    len_known = 1'b1;
    case (view[1])
      pkfr_pkg::CHAR_A: len = cfg.accel_len;
      pkfr_pkg::CHAR_G: len = cfg.gyro_len;
      pkfr_pkg::CHAR_M: len = cfg.magnet_len;
      pkfr_pkg::CHAR_Q: len = cfg.quat_len;
      pkfr_pkg::CHAR_B: len = cfg.button_len;
      pkfr_pkg::CHAR_C: len = cfg.color_len;
      pkfr_pkg::CHAR_L: len = cfg.location_len;
      default: begin
        len       = '0;
        len_known = 1'b0;
      end
    endcase
    len_hit = len_known && (CW'(newpos) == CW'(len));
    if (is_byte) begin
      close = (newpos == PW'(BUFFER_BYTES)) || len_hit;
      cpos  = newpos;
    end else begin
      close = (idle_next >= cfg.idle_limit);
      cpos  = pos;
    end
    // The byte at the closing position reads as zero.
    for (int i = 0; i < DB; i++) begin
      eff[i] = (cpos == PW'(i)) ? 8'h00 : view[i];
    end
    emit = close && (cpos != '0) &&
           ((eff[1] == pkfr_pkg::CHAR_A) || (eff[1] == pkfr_pkg::CHAR_B));
    q_entry.kind = (eff[1] == pkfr_pkg::CHAR_A);
    for (int j = 0; j < PB; j++) begin
      q_entry.data[j] = eff[j + 2];
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt        <= '0;
      pos        <= '0;
      idle_count <= '0;
    end else if (accept) begin
      if (close) begin
        pkt        <= '0;
        pos        <= '0;
        idle_count <= '0;
      end else if (is_byte) begin
        pkt        <= view;
        pos        <= newpos;
        idle_count <= '0;
      end else begin
        idle_count <= idle_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pkfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer result queue
// Two-entry register queue between the framing front end and the decoder.
// ----------------------------------------------------------------------------
module pkfr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pkfr_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  avail,
  output pkfr_pkg::entry_t      head
);

  pkfr_pkg::entry_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pkfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer back end
// Decodes a queued packet head into a button or accelerometer result and
// holds it in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module pkfr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_avail,
  input  wire pkfr_pkg::entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  kind,
  output logic [7:0]            button_number,
  output logic [7:0]            button_pressed,
  output logic [31:0]           accel_x_bits,
  output logic [31:0]           accel_y_bits,
  output logic [31:0]           accel_z_bits
);

  logic load;

  assign load  = q_avail && (!out_valid || !out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= q_head.kind;
      if (q_head.kind) begin
        button_number  <= '0;
        button_pressed <= '0;
        accel_x_bits   <= {q_head.data[3], q_head.data[2], q_head.data[1], q_head.data[0]};
        accel_y_bits   <= {q_head.data[7], q_head.data[6], q_head.data[5], q_head.data[4]};
        accel_z_bits   <= {q_head.data[11], q_head.data[10], q_head.data[9], q_head.data[8]};
      end else begin
        button_number  <= q_head.data[0] - pkfr_pkg::CHAR_ZERO;
        button_pressed <= q_head.data[1] - pkfr_pkg::CHAR_ZERO;
        accel_x_bits   <= '0;
        accel_y_bits   <= '0;
        accel_z_bits   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ble_controller_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer
// Frames received bytes into controller packets and reports button and
// accelerometer packets.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Fields
//  in       in_valid/in_stall   action, rx_byte
//  out      out_valid/out_stall kind, button_number, button_pressed, accel_*_bits
//  cfg      cfg_write           cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; a result reaches the
// outputs through the queue and the output register after the item that closed
// its packet. The front end registers the framing state, and a two-entry queue
// feeds the decoder. Input stalls only while both queue entries hold results.
// Reset clears the packet buffer, position, idle count and queue, and loads register defaults.
// ----------------------------------------------------------------------------
module ble_controller_packet_framer #(
  parameter int BUFFER_BYTES = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       button_number,
  output logic [7:0]       button_pressed,
  output logic [31:0]      accel_x_bits,
  output logic [31:0]      accel_y_bits,
  output logic [31:0]      accel_z_bits
);

  typedef enum logic [2:0] {
    REG_IDLE_LIMIT = 3'd0,
    REG_ACCEL_LEN  = 3'd1,
    REG_GYRO_LEN   = 3'd2,
    REG_MAGNET_LEN = 3'd3,
    REG_QUAT_LEN   = 3'd4,
    REG_BUTTON_LEN = 3'd5,
    REG_COLOR_LEN  = 3'd6,
    REG_LOC_LEN    = 3'd7
  } reg_index_t;

  pkfr_pkg::cfg_t   cfg;
  pkfr_pkg::entry_t q_in;
  pkfr_pkg::entry_t q_head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_limit   <= 16'd500;
      cfg.accel_len    <= 5'd15;
      cfg.gyro_len     <= 5'd15;
      cfg.magnet_len   <= 5'd15;
      cfg.quat_len     <= 5'd19;
      cfg.button_len   <= 5'd5;
      cfg.color_len    <= 5'd6;
      cfg.location_len <= 5'd15;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_IDLE_LIMIT: cfg.idle_limit   <= cfg_data;
        REG_ACCEL_LEN:  cfg.accel_len    <= cfg_data[4:0];
        REG_GYRO_LEN:   cfg.gyro_len     <= cfg_data[4:0];
        REG_MAGNET_LEN: cfg.magnet_len   <= cfg_data[4:0];
        REG_QUAT_LEN:   cfg.quat_len     <= cfg_data[4:0];
        REG_BUTTON_LEN: cfg.button_len   <= cfg_data[4:0];
        REG_COLOR_LEN:  cfg.color_len    <= cfg_data[4:0];
        REG_LOC_LEN:    cfg.location_len <= cfg_data[4:0];
        default:        cfg.idle_limit   <= cfg.idle_limit;
      endcase
    end
  end

  pkfr_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  pkfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  pkfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_avail        (q_avail),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .button_number  (button_number),
    .button_pressed (button_pressed),
    .accel_x_bits   (accel_x_bits),
    .accel_y_bits   (accel_y_bits),
    .accel_z_bits   (accel_z_bits)
  );

endmodule
`default_nettype wire

// File: rtl/pkfr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Controller packet framer checker
// Port-level checks on the result channel of the framer.
// ----------------------------------------------------------------------------
module pkfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        kind,
  input wire logic [7:0]  button_number,
  input wire logic [7:0]  button_pressed,
  input wire logic [31:0] accel_x_bits,
  input wire logic [31:0] accel_y_bits,
  input wire logic [31:0] accel_z_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) &&
      $stable(button_number) && $stable(button_pressed) &&
      $stable(accel_x_bits) && $stable(accel_y_bits) && $stable(accel_z_bits))
    else $error("stalled result changed");

  a_button_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> accel_x_bits == 32'd0 && accel_y_bits == 32'd0 &&
      accel_z_bits == 32'd0)
    else $error("button result carries accelerometer data");

  a_accel_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> button_number == 8'd0 && button_pressed == 8'd0)
    else $error("accelerometer result carries button data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ble_controller_packet_framer pkfr_checker u_pkfr_checker (.*);
`default_nettype wire
